// ===== sv/tcpf_pkg.sv =====
// Shared constants, codes and types for the two-class priority FIFO.
package tcpf_pkg;

	// Sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int STORE_W     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int TOTAL_W     = 6;
	localparam int ADDR_W      = 3;

	// Operation codes
	localparam logic [1:0] OP_ENQ     = 2'd0;
	localparam logic [1:0] OP_DEQ     = 2'd1;
	localparam logic [1:0] OP_PEEK    = 2'd2;
	localparam logic [1:0] OP_PROMOTE = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_SINGLE = 2'd3;

	// Register indexes
	localparam logic REG_DUAL_MODE = 1'b0;

	// Per-queue control for one cycle
	typedef struct packed {
		logic push;
		logic pop;
	} tcpf_qctl_t;

endpackage

// ===== sv/tcpf_cell.sv =====
// One storage cell of a queue chain: loads a new value or takes its neighbor's.
module tcpf_cell (
	input  logic                        clk,
	input  logic                        load_en,
	input  logic                        shift_en,
	input  logic [tcpf_pkg::STORE_W-1:0] wdata,
	input  logic [tcpf_pkg::STORE_W-1:0] next_value,
	output logic [tcpf_pkg::STORE_W-1:0] value
);
	import tcpf_pkg::*;

	logic [STORE_W-1:0] value_q;

	// Load wins; otherwise shift toward the head on a pop
	always_ff @(posedge clk) begin
		if (load_en) begin
			value_q <= wdata;
		end else if (shift_en) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;

endmodule

// ===== sv/tcpf_queue.sv =====
// One FIFO built as a shift chain of cells; the head always sits in cell 0.
module tcpf_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcpf_pkg::tcpf_qctl_t         ctl,
	input  logic [tcpf_pkg::STORE_W-1:0] wdata,
	output logic [tcpf_pkg::STORE_W-1:0] head_value,
	output logic [tcpf_pkg::FILL_W-1:0]  fill,
	output logic [tcpf_pkg::FILL_W-1:0]  fill_nx
);
	import tcpf_pkg::*;

	logic [STORE_W-1:0] cell_val [QUEUE_DEPTH];
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  tail_idx;

	// Tail slot after a simultaneous pop moves one place down
	assign tail_idx = ctl.pop ? (fill_q - FILL_W'(1)) : fill_q;

	// Cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [STORE_W-1:0] nbr;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nbr = cell_val[i];
		end else begin : g_mid
			assign nbr = cell_val[i+1];
		end
		tcpf_cell u_cell (
			.clk        (clk),
			.load_en    (ctl.push && (tail_idx == FILL_W'(i))),
			.shift_en   (ctl.pop),
			.wdata      (wdata),
			.next_value (nbr),
			.value      (cell_val[i])
		);
	end

	// Fill count
	always_comb begin
		fill_nx = fill_q;
		if (ctl.push && !ctl.pop) begin
			fill_nx = fill_q + FILL_W'(1);
		end else if (ctl.pop && !ctl.push) begin
			fill_nx = fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nx;
		end
	end

	assign head_value = cell_val[0];
	assign fill       = fill_q;

endmodule

// ===== sv/two_class_priority_fifo_top.sv =====
// Top level: two-class strict priority FIFO with APB mode register.
// Two queues of QUEUE_DEPTH entries, normal and urgent, each a chain of cells with the head
// in the first cell. Enqueue goes to urgent when the urgent bit is set in dual mode, else to
// normal; dequeue and peek serve urgent first; promote moves the normal head to the urgent
// tail. Each transaction yields one result (value, status, total count) held in an output
// register. One transaction is taken per cycle as long as the
// output side takes results; the only thing that holds input back is a full output register
// that is stalled. Full, empty and promote-in-single-mode return a status and change nothing.
// The dual_mode register (byte address 0, reset 1) must only be written while the block is idle.
module two_class_priority_fifo_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcpf_pkg::ADDR_W-1:0]  paddr,
	input  logic [tcpf_pkg::DATA_W-1:0]  pwdata,
	output logic [tcpf_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic                         urgent,
	input  logic [31:0]                  payload,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  result_value,
	output logic [1:0]                   status,
	output logic [tcpf_pkg::TOTAL_W-1:0] total_count
);
	import tcpf_pkg::*;

	logic               dual_q;
	logic               in_acc;
	logic               out_acc;
	tcpf_qctl_t         n_ctl;
	tcpf_qctl_t         u_ctl;
	logic [STORE_W-1:0] n_head;
	logic [STORE_W-1:0] u_head;
	logic [STORE_W-1:0] u_wdata;
	logic [FILL_W-1:0]  n_fill;
	logic [FILL_W-1:0]  u_fill;
	logic [FILL_W-1:0]  n_fill_nx;
	logic [FILL_W-1:0]  u_fill_nx;
	logic               n_empty;
	logic               n_full;
	logic               u_empty;
	logic               u_full;
	logic [STORE_W-1:0] value_nx;
	logic [1:0]         status_nx;
	logic [TOTAL_W-1:0] total_nx;
	logic               out_valid_q;
	logic [31:0]        result_value_q;
	logic [1:0]         status_q;
	logic [TOTAL_W-1:0] total_q;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DUAL_MODE) ? DATA_W'(dual_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DUAL_MODE)) begin
			dual_q <= pwdata[0];
		end
	end

	// Handshakes
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;

	assign n_empty = (n_fill == '0);
	assign u_empty = (u_fill == '0);
	assign n_full  = (n_fill == FILL_W'(QUEUE_DEPTH));
	assign u_full  = (u_fill == FILL_W'(QUEUE_DEPTH));

	assign u_wdata = (opcode == OP_PROMOTE) ? n_head : payload[STORE_W-1:0];

	// Operation decode
	always_comb begin
		n_ctl     = '0;
		u_ctl     = '0;
		value_nx  = '0;
		status_nx = ST_OK;
		unique case (opcode)
			OP_ENQ: begin
				if (dual_q && urgent) begin
					if (u_full) status_nx = ST_FULL;
					else        u_ctl.push = in_acc;
				end else begin
					if (n_full) status_nx = ST_FULL;
					else        n_ctl.push = in_acc;
				end
			end
			OP_DEQ, OP_PEEK: begin
				priority if (dual_q && !u_empty) begin
					value_nx  = u_head;
					u_ctl.pop = in_acc && (opcode == OP_DEQ);
				end else if (n_empty) begin
					status_nx = ST_EMPTY;
				end else begin
					value_nx  = n_head;
					n_ctl.pop = in_acc && (opcode == OP_DEQ);
				end
			end
			OP_PROMOTE: begin
				priority if (!dual_q) begin
					status_nx = ST_SINGLE;
				end else if (n_empty) begin
					status_nx = ST_EMPTY;
				end else if (u_full) begin
					status_nx = ST_FULL;
				end else begin
					n_ctl.pop  = in_acc;
					u_ctl.push = in_acc;
				end
			end
			default: status_nx = ST_OK;
		endcase
	end

	// Count after this step
	assign total_nx = TOTAL_W'(n_fill_nx) + (dual_q ? TOTAL_W'(u_fill_nx) : TOTAL_W'(0));

	// Queues
	tcpf_queue u_normal (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (n_ctl),
		.wdata      (payload[STORE_W-1:0]),
		.head_value (n_head),
		.fill       (n_fill),
		.fill_nx    (n_fill_nx)
	);

	tcpf_queue u_urgent (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (u_ctl),
		.wdata      (u_wdata),
		.head_value (u_head),
		.fill       (u_fill),
		.fill_nx    (u_fill_nx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_value_q <= 32'(value_nx);
			status_q       <= status_nx;
			total_q        <= total_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign total_count  = total_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(n_fill <= FILL_W'(QUEUE_DEPTH)) && (u_fill <= FILL_W'(QUEUE_DEPTH)))
		else $error("queue fill count beyond depth");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (status_nx != ST_OK)) |=> ($stable(n_fill) && $stable(u_fill)))
		else $error("failed transaction changed a queue");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted transaction produced no result");

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (result_value == '0))
		else $error("nonzero value with error status");

endmodule
